// ===== hw/rtl/ps2mct_pkg.sv =====
// Package for the PS/2 mouse packet cursor tracker.
// Holds the flag-byte bit positions, field widths and the packet struct.
// Has no dependencies.
`default_nettype none

package ps2mct_pkg;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 12;
    localparam int BTN_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Bit positions within the flags byte.
    localparam int BTN_LSB      = 0;
    localparam int SYNC_BIT     = 3;
    localparam int X_SIGN_BIT   = 4;
    localparam int Y_SIGN_BIT   = 5;
    localparam int X_OVF_BIT    = 6;
    localparam int Y_OVF_BIT    = 7;

    localparam logic [COORD_W-1:0] X_LIMIT_RESET = 12'd1023;
    localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 12'd767;
    localparam logic [COORD_W-1:0] POS_X_RESET   = 12'd400;
    localparam logic [COORD_W-1:0] POS_Y_RESET   = 12'd300;

    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 1'b1;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } packet_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ps2_mouse_packet_cursor_tracker.sv =====
// Top level of the PS/2 mouse packet cursor tracker.
// Instantiates ps2mct_framer and applies each packet to the cursor position.
// Depends on ps2mct_pkg.
//
// Mouse bytes arrive one item at a time on the s_axis channel. Every third
// byte of a packet that passes the sync check and has no overflow flag yields
// one item on the m_axis channel carrying the clamped cursor X, cursor Y and
// the three button bits. Dropped sync bytes and overflowed packets give no item.
// A byte passes through an input register and then the result register. One
// byte is taken every cycle unless a held result is stalled; the input
// register, the packet framer and the result register all advance together
// on one enable, so when the receiver stalls a held result, the whole path
// freezes and s_axis_tready falls until the result is taken. The limits are
// written through the cfg port, by the user only while the block is idle;
// the block itself does not enforce this. Reset sets the limits to 1023 and
// 767, the cursor to (400, 300), and restarts packet framing at the flags byte.
`default_nettype none

module ps2_mouse_packet_cursor_tracker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // rx_byte[7:0]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [31:0]                             m_axis_tdata,  // cursor_x[11:0],
                                                                   // cursor_y[23:12],
                                                                   // button_bits[26:24]
    input  wire logic                               cfg_we,
    input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ps2mct_pkg::COORD_W-1:0]     cfg_data
);
    import ps2mct_pkg::*;

    localparam int SUM_W = COORD_W + 2;

    logic                advance;
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    packet_t             packet;

    logic [COORD_W-1:0]  x_limit_reg;
    logic [COORD_W-1:0]  y_limit_reg;
    logic [COORD_W-1:0]  pos_x_reg;
    logic [COORD_W-1:0]  pos_y_reg;
    logic [COORD_W-1:0]  pos_x_next;
    logic [COORD_W-1:0]  pos_y_next;
    logic                accept_pkt;

    logic                out_valid_reg;
    logic [COORD_W-1:0]  out_x_reg;
    logic [COORD_W-1:0]  out_y_reg;
    logic [BTN_W-1:0]    out_btn_reg;

    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    ps2mct_framer u_framer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (advance && in_valid_reg),
        .rx_byte (in_byte_reg),
        .packet  (packet)
    );

    assign accept_pkt = packet.done && !packet.flags[X_OVF_BIT] && !packet.flags[Y_OVF_BIT];

    always_comb
    begin
        dx = {{(SUM_W-BYTE_W-1){packet.flags[X_SIGN_BIT]}}, packet.flags[X_SIGN_BIT],
              packet.x_byte};
        dy = {{(SUM_W-BYTE_W-1){packet.flags[Y_SIGN_BIT]}}, packet.flags[Y_SIGN_BIT],
              packet.y_byte};
        nx = $signed({2'b00, pos_x_reg}) + dx;
        ny = $signed({2'b00, pos_y_reg}) - dy;

        priority if (nx < 0)
            pos_x_next = '0;
        else if (nx > $signed({2'b00, x_limit_reg}))
            pos_x_next = x_limit_reg;
        else
            pos_x_next = nx[COORD_W-1:0];

        priority if (ny < 0)
            pos_y_next = '0;
        else if (ny > $signed({2'b00, y_limit_reg}))
            pos_y_next = y_limit_reg;
        else
            pos_y_next = ny[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x_limit_reg   <= X_LIMIT_RESET;
            y_limit_reg   <= Y_LIMIT_RESET;
            pos_x_reg     <= POS_X_RESET;
            pos_y_reg     <= POS_Y_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_X_LIMIT: x_limit_reg <= cfg_data;
                    REG_Y_LIMIT: y_limit_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (advance)
            begin
                in_valid_reg  <= s_axis_tvalid;
                out_valid_reg <= in_valid_reg && accept_pkt;
                if (in_valid_reg && accept_pkt)
                begin
                    pos_x_reg <= pos_x_next;
                    pos_y_reg <= pos_y_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_byte_reg <= s_axis_tdata;
            if (in_valid_reg && accept_pkt)
            begin
                out_x_reg   <= pos_x_next;
                out_y_reg   <= pos_y_next;
                out_btn_reg <= packet.flags[BTN_LSB +: BTN_W];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_btn_reg, out_y_reg, out_x_reg};

    // A fresh result always follows a byte that sat in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a byte in the input register");

    // The cursor moves only when a packet is applied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg && accept_pkt) |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("cursor changed without an accepted packet");

    // A newly loaded result lies within the limits it was clamped to.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && accept_pkt && !cfg_we
        |=> out_x_reg <= x_limit_reg && out_y_reg <= y_limit_reg)
        else $error("result outside the cursor limits");

    // The result register mirrors the cursor position while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_x_reg == pos_x_reg && out_y_reg == pos_y_reg)
        else $error("held result differs from the cursor position");

endmodule

`default_nettype wire

// ===== hw/rtl/ps2mct_framer.sv =====
// Gathers mouse bytes into three-byte packets and keeps the stream in sync.
// Depends on ps2mct_pkg for the packet struct and flag bit positions.
`default_nettype none

module ps2mct_framer
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        byte_en,
    input  wire logic [ps2mct_pkg::BYTE_W-1:0] rx_byte,
    output ps2mct_pkg::packet_t              packet
);
    import ps2mct_pkg::*;

    localparam logic [1:0] POS_FLAGS = 2'd0;
    localparam logic [1:0] POS_X     = 2'd1;
    localparam logic [1:0] POS_Y     = 2'd2;

    logic [1:0]        pos_reg;
    logic [1:0]        pos_next;
    logic [BYTE_W-1:0] flags_reg;
    logic [BYTE_W-1:0] x_byte_reg;

    always_comb
    begin
        pos_next = pos_reg;
        packet.done   = 1'b0;
        packet.flags  = flags_reg;
        packet.x_byte = x_byte_reg;
        packet.y_byte = rx_byte;
        if (byte_en)
        begin
            unique case (pos_reg)
                POS_FLAGS:
                begin
                    if (rx_byte[SYNC_BIT])
                    begin
                        pos_next = POS_X;
                    end
                end
                POS_X:
                begin
                    pos_next = POS_Y;
                end
                default:
                begin
                    // The third byte, also taken for the unreachable fourth code.
                    pos_next    = POS_FLAGS;
                    packet.done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FLAGS;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en && pos_reg == POS_FLAGS && rx_byte[SYNC_BIT])
        begin
            flags_reg <= rx_byte;
        end
        if (byte_en && pos_reg == POS_X)
        begin
            x_byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire
